@@ hdl/rpn_pkg.sv @@
package rpn_pkg;

   // Result status codes, one for each check that can fail.
   localparam logic [3:0] ST_OK     = 4'd0;
   localparam logic [3:0] ST_EDGE   = 4'd1;
   localparam logic [3:0] ST_START  = 4'd2;
   localparam logic [3:0] ST_ENDDIG = 4'd3;
   localparam logic [3:0] ST_BADCH  = 4'd4;
   localparam logic [3:0] ST_UNSEP  = 4'd5;
   localparam logic [3:0] ST_FEW    = 4'd6;
   localparam logic [3:0] ST_DIV0   = 4'd7;
   localparam logic [3:0] ST_LEFT   = 4'd8;
   localparam logic [3:0] ST_OVF    = 4'd9;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam int unsigned DATA_W = 32;

   // Request to the shared multiply/divide unit.
   typedef struct packed {
      logic              start;
      logic              is_div;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } md_req_type;

   // Answer from the multiply/divide unit; done is a one-cycle pulse.
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } md_rsp_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

@@ hdl/rpn_ram.sv @@
module rpn_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rpn_muldiv.sv @@
module rpn_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  rpn_pkg::md_req_type md_req,
   output rpn_pkg::md_rsp_type md_rsp
);

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_RUN,
      MD_FIX
   } md_state_type;

   md_state_type state_ff;
   logic         is_div_ff;
   logic         neg_ff;
   logic [31:0]  ma_ff;
   logic [31:0]  mb_ff;
   logic [31:0]  acc_ff;
   logic [31:0]  rem_ff;
   logic [4:0]   cnt_ff;
   logic         done_ff;
   logic [31:0]  result_ff;

   logic [31:0]  abs_a;
   logic [31:0]  abs_b;
   logic [32:0]  shifted;
   logic [33:0]  trial;

   always_comb begin
      abs_a   = md_req.a[31] ? (32'd0 - md_req.a) : md_req.a;
      abs_b   = md_req.b[31] ? (32'd0 - md_req.b) : md_req.b;
      shifted = {rem_ff, ma_ff[31]};
      trial   = {1'b0, shifted} - {2'b00, mb_ff};
   end

   // Multiply: shift-add, one multiplier bit per cycle.
   // Divide: restoring division on magnitudes, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            MD_IDLE: begin
               if (md_req.start) begin
                  is_div_ff <= md_req.is_div;
                  neg_ff    <= md_req.a[31] ^ md_req.b[31];
                  ma_ff     <= md_req.is_div ? abs_a : md_req.a;
                  mb_ff     <= md_req.is_div ? abs_b : md_req.b;
                  acc_ff    <= '0;
                  rem_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= MD_RUN;
               end
            end
            MD_RUN: begin
               if (is_div_ff) begin
                  if (!trial[33]) begin
                     rem_ff <= trial[31:0];
                     acc_ff <= {acc_ff[30:0], 1'b1};
                  end else begin
                     rem_ff <= shifted[31:0];
                     acc_ff <= {acc_ff[30:0], 1'b0};
                  end
               end else begin
                  if (mb_ff[0]) begin
                     acc_ff <= acc_ff + ma_ff;
                  end
                  mb_ff <= {1'b0, mb_ff[31:1]};
               end
               ma_ff  <= {ma_ff[30:0], 1'b0};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= MD_FIX;
               end
            end
            MD_FIX: begin
               result_ff <= (is_div_ff && neg_ff) ? (32'd0 - acc_ff) : acc_ff;
               done_ff   <= 1'b1;
               state_ff  <= MD_IDLE;
            end
            default: begin
               state_ff <= MD_IDLE;
            end
         endcase
      end
   end

   assign md_rsp.done   = done_ff;
   assign md_rsp.result = result_ff;

endmodule

@@ hdl/rpn_expression_evaluator_unit.sv @@
// Reverse Polish notation evaluator. The expression arrives on the req_ channel one ASCII
// character per item, with req_tlast on its final character; digits push 0..9, and the
// operators + - * / pop two values and push the 32-bit wrapped result (division truncates
// toward zero). One result item leaves on the rsp_ channel for each expression, after its
// last character: the value (zero unless the status is ok) and a status code. Edge space, bad
// start and ends digit are checked first, in that order; next comes the earliest error found
// among bad character, unseparated characters, too few operands, divide by zero and stack
// overflow; leftover operands is checked last. A character is executed only when the
// following one has arrived. The block takes no new character until it is through with the
// last one, and the final character of an expression also waits for the result register to
// empty. * and / run on a shared shift-and-add / restoring-divide unit that produces one
// bit per cycle, while the block waits for it. The operand stack lives in a
// single-port-write, registered-read RAM of STACK_DEPTH words, with the top of stack held
// in a register; the stack needs no clearing after reset because only entries below the
// stack count are ever read. The stack state is cleared after every expression. The last
// item's result sits in an output register, and the next expression is taken in while it
// waits to be collected.
module rpn_expression_evaluator_unit #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] value, [35:32] status, [39:36] zero
);

   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_EXEC,
      S_READ,
      S_WAIT,
      S_POST,
      S_LAST,
      S_FINAL
   } state_type;

   state_type        state_ff;
   logic [7:0]       char_ff;
   logic             last_ff;
   logic [7:0]       pending_ff;
   logic             pending_valid_ff;
   logic [7:0]       first_ff;
   logic [3:0]       err_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      tos_ff;
   logic [7:0]       exec_ff;
   logic             phase_ff;   // set while executing the final character
   logic             rsp_valid_ff;
   logic [31:0]      rsp_value_ff;
   logic [3:0]       rsp_status_ff;

   logic             ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic             ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [31:0]      ram_rd_data;

   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] count_m2;
   logic             stack_full;
   logic             stack_few;
   logic             exec_digit;
   logic             exec_op;
   logic [31:0]      digit_value;
   logic [31:0]      sum;
   logic [31:0]      diff;
   logic             slot_free;
   logic [3:0]       final_status;
   state_type        after_exec;

   rpn_pkg::md_req_type md_req;
   rpn_pkg::md_rsp_type md_rsp;

   always_comb begin
      count_m1    = count_ff - CNT_W'(1);
      count_m2    = count_ff - CNT_W'(2);
      stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
      stack_few   = (count_ff < CNT_W'(2));
      exec_digit  = rpn_pkg::is_digit(exec_ff);
      exec_op     = rpn_pkg::is_op(exec_ff);
      digit_value = {24'd0, exec_ff - rpn_pkg::CH_ZERO};
      sum         = ram_rd_data + tos_ff;
      diff        = ram_rd_data - tos_ff;
      slot_free   = !rsp_valid_ff || rsp_tready;
      after_exec  = phase_ff ? S_FINAL : S_POST;

      // A push spills the old top of stack into the RAM; an operator fetches the
      // entry below the top. The sequencer never reads an entry in the cycle it is
      // written, so no forwarding is needed.
      ram_wr_en   = (state_ff == S_EXEC) && exec_digit && !stack_full
                    && (count_ff != '0);
      ram_wr_addr = count_m1[ADDR_W-1:0];
      ram_rd_en   = (state_ff == S_EXEC) && exec_op && !stack_few;
      ram_rd_addr = count_m2[ADDR_W-1:0];

      md_req.start  = (state_ff == S_READ)
                      && ((exec_ff == rpn_pkg::CH_STAR)
                          || ((exec_ff == rpn_pkg::CH_SLASH) && (tos_ff != '0)));
      md_req.is_div = (exec_ff == rpn_pkg::CH_SLASH);
      md_req.a      = ram_rd_data;
      md_req.b      = tos_ff;

      priority if (rpn_pkg::is_ws(first_ff) || rpn_pkg::is_ws(char_ff)) begin
         final_status = rpn_pkg::ST_EDGE;
      end else if (!rpn_pkg::is_digit(first_ff)) begin
         final_status = rpn_pkg::ST_START;
      end else if (rpn_pkg::is_digit(char_ff)) begin
         final_status = rpn_pkg::ST_ENDDIG;
      end else if (err_ff != rpn_pkg::ST_OK) begin
         final_status = err_ff;
      end else if (count_ff != CNT_W'(1)) begin
         final_status = rpn_pkg::ST_LEFT;
      end else begin
         final_status = rpn_pkg::ST_OK;
      end
   end

   rpn_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (tos_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rpn_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         pending_ff       <= '0;
         pending_valid_ff <= 1'b0;
         first_ff         <= '0;
         err_ff           <= rpn_pkg::ST_OK;
         count_ff         <= '0;
         phase_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // The final step loads the result register itself, so the clear is left to it there.
         if (rsp_valid_ff && rsp_tready && (state_ff != S_FINAL)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  char_ff  <= req_tdata;
                  last_ff  <= req_tlast;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               // Separation check of the held character against the new one
               // comes before the held character is executed.
               if (!pending_valid_ff) begin
                  first_ff <= char_ff;
               end
               phase_ff <= 1'b0;
               exec_ff  <= pending_ff;
               if ((err_ff == rpn_pkg::ST_OK) && pending_valid_ff) begin
                  if ((pending_ff != rpn_pkg::CH_SPACE) && (char_ff != rpn_pkg::CH_SPACE)) begin
                     err_ff   <= rpn_pkg::ST_UNSEP;
                     state_ff <= S_POST;
                  end else begin
                     state_ff <= S_EXEC;
                  end
               end else begin
                  state_ff <= S_POST;
               end
            end
            S_EXEC: begin
               if (exec_digit) begin
                  if (stack_full) begin
                     err_ff <= rpn_pkg::ST_OVF;
                  end else begin
                     tos_ff   <= digit_value;
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  state_ff <= after_exec;
               end else if (exec_op) begin
                  if (stack_few) begin
                     err_ff   <= rpn_pkg::ST_FEW;
                     state_ff <= after_exec;
                  end else begin
                     state_ff <= S_READ;
                  end
               end else begin
                  state_ff <= after_exec;
               end
            end
            S_READ: begin
               // Second operand from the RAM is valid now; top of stack is tos_ff.
               if (exec_ff == rpn_pkg::CH_PLUS) begin
                  tos_ff   <= sum;
                  count_ff <= count_m1;
                  state_ff <= after_exec;
               end else if (exec_ff == rpn_pkg::CH_MINUS) begin
                  tos_ff   <= diff;
                  count_ff <= count_m1;
                  state_ff <= after_exec;
               end else if ((exec_ff == rpn_pkg::CH_SLASH) && (tos_ff == '0)) begin
                  err_ff   <= rpn_pkg::ST_DIV0;
                  state_ff <= after_exec;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (md_rsp.done) begin
                  tos_ff   <= md_rsp.result;
                  count_ff <= count_m1;
                  state_ff <= after_exec;
               end
            end
            S_POST: begin
               if ((err_ff == rpn_pkg::ST_OK) && !rpn_pkg::is_digit(char_ff)
                   && !rpn_pkg::is_op(char_ff) && (char_ff != rpn_pkg::CH_SPACE)) begin
                  err_ff <= rpn_pkg::ST_BADCH;
               end
               pending_ff       <= char_ff;
               pending_valid_ff <= 1'b1;
               state_ff         <= last_ff ? S_LAST : S_IDLE;
            end
            S_LAST: begin
               phase_ff <= 1'b1;
               exec_ff  <= char_ff;
               state_ff <= (err_ff == rpn_pkg::ST_OK) ? S_EXEC : S_FINAL;
            end
            S_FINAL: begin
               if (slot_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= final_status;
                  rsp_value_ff     <= (final_status == rpn_pkg::ST_OK) ? tos_ff : '0;
                  count_ff         <= '0;
                  pending_ff       <= '0;
                  pending_valid_ff <= 1'b0;
                  first_ff         <= '0;
                  err_ff           <= rpn_pkg::ST_OK;
                  phase_ff         <= 1'b0;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_status_ff, rsp_value_ff};

   // A result item appears only from the final step of an expression.
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINAL))
      else $error("result raised outside the final step");

   // The stack count never passes the stack depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // The multiply/divide unit only answers while the sequencer waits for it.
   a_md_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> (state_ff == S_WAIT))
      else $error("multiply/divide result outside wait step");

   // An erroneous result carries a zero value.
   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != rpn_pkg::ST_OK)) |-> (rsp_value_ff == '0))
      else $error("nonzero value with error status");

endmodule
